@@ hw/rtl/four_ary_min_heap_queue_core_macros.svh @@
// ----------------------------------------------------------------------------
// heap queue assertion macros
// shared property forms for the heap queue checker
// ----------------------------------------------------------------------------
`ifndef FOUR_ARY_MIN_HEAP_QUEUE_CORE_MACROS_SVH
`define FOUR_ARY_MIN_HEAP_QUEUE_CORE_MACROS_SVH

// same-cycle implication
`define FAHQ_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FAHQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/fahq_pkg.sv @@
// ----------------------------------------------------------------------------
// heap queue package
// field widths, command and status codes, slot word and rank compare
// ----------------------------------------------------------------------------
`default_nettype none

package fahq_pkg;

   localparam int RT_W   = 64;
   localparam int WT_W   = 16;
   localparam int ID_W   = 8;
   localparam int MODE_W = 2;
   localparam int STAT_W = 3;

   localparam int DEF_CAPACITY = 256;
   localparam int DEF_ARITY    = 4;
   localparam int DEF_ID_COUNT = 256;

   localparam logic [MODE_W-1:0] MODE_PUSH   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ERASE  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_PEEK   = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd1;
   localparam logic [STAT_W-1:0] ST_FULL    = 3'd2;
   localparam logic [STAT_W-1:0] ST_ABSENT  = 3'd3;
   localparam logic [STAT_W-1:0] ST_PRESENT = 3'd4;

   typedef struct packed {
      logic [RT_W-1:0] runtime;
      logic [WT_W-1:0] weight;
      logic [ID_W-1:0] id;
   } entry_type;

   // lower runtime first, higher weight on equal runtime
   function automatic logic ranks_ahead(input entry_type a, input entry_type b);
      logic r;
      if (a.runtime != b.runtime) begin
         r = (a.runtime < b.runtime);
      end else begin
         r = (a.weight > b.weight);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/fahq_ram.sv @@
// ----------------------------------------------------------------------------
// heap queue ram
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module fahq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/four_ary_min_heap_queue_core.sv @@
// ----------------------------------------------------------------------------
// four-ary min-heap queue core
// Priority queue of scheduler entries held in a d-ary heap in block ram.
//
// Command channel: a word is taken at a rising edge with start high and busy
// low; busy stays high until the command is done. Modes are push, remove
// minimum, erase by id and peek minimum.
// Result channel: one word per command, shown for one cycle with rsp_strobe
// high; the receiver cannot stall it. busy is low in that cycle, so the next
// word can be taken at the edge that takes the result.
// Order of work: a rejected command is answered from idle; peek reads the top.
//   push climbs from the new last slot, reading and comparing one parent at a
//   time, then writes the entry into the hole. remove reads the top and the
//   last slot and answers when that empties the queue; else it walks down
//   from the top, reading the children of each level. erase reads the slot
//   of the id and the last slot, answers when the last slot goes, else climbs,
//   plus the remove walk when nothing climbs.
// Each compare waits on the registered single read port of the slot ram.
// Reset empties the queue at once (id valid bits in flops, slot count to
// zero) and clears the last removed runtime; no clearing pass is run.
// ----------------------------------------------------------------------------
`default_nettype none

module four_ary_min_heap_queue_core #(
   parameter int CAPACITY = fahq_pkg::DEF_CAPACITY,
   parameter int ARITY    = fahq_pkg::DEF_ARITY,
   parameter int ID_COUNT = fahq_pkg::DEF_ID_COUNT,
   localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [fahq_pkg::MODE_W-1:0] req_mode,
   input  wire logic [fahq_pkg::ID_W-1:0]   req_entry_id,
   input  wire logic [fahq_pkg::RT_W-1:0]   req_key_runtime,
   input  wire logic [fahq_pkg::WT_W-1:0]   req_entry_weight,
   output logic                             rsp_strobe,
   output logic      [fahq_pkg::STAT_W-1:0] rsp_status,
   output logic      [fahq_pkg::ID_W-1:0]   rsp_out_id,
   output logic      [fahq_pkg::RT_W-1:0]   rsp_out_runtime,
   output logic      [fahq_pkg::WT_W-1:0]   rsp_out_weight,
   output logic      [CNT_W-1:0]            rsp_entry_count,
   output logic      [fahq_pkg::RT_W-1:0]   rsp_last_removed_runtime
);

   localparam int SLOT_W = $clog2(CAPACITY);
   localparam int IDX_W  = $clog2(ID_COUNT);
   localparam int DIV_L  = $clog2(ARITY);
   localparam int DIV_S  = SLOT_W + DIV_L;
   localparam int PROD_W = 2 * SLOT_W + DIV_L + 1;
   localparam logic [PROD_W-1:0] DIV_M =
      PROD_W'(((64'd1 << DIV_S) + 64'(ARITY) - 64'd1) / 64'(ARITY));
   localparam int CH_W   = SLOT_W + DIV_L + 1;
   localparam int KW     = $clog2(ARITY + 1);
   localparam int ENT_W  = $bits(fahq_pkg::entry_type);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_UP   = 4'd1;
   localparam logic [3:0] S_UPR  = 4'd2;
   localparam logic [3:0] S_UPC  = 4'd3;
   localparam logic [3:0] S_WR   = 4'd4;
   localparam logic [3:0] S_DN   = 4'd5;
   localparam logic [3:0] S_DNS  = 4'd6;
   localparam logic [3:0] S_DNE  = 4'd7;
   localparam logic [3:0] S_RM0  = 4'd8;
   localparam logic [3:0] S_RM1  = 4'd9;
   localparam logic [3:0] S_ER0  = 4'd10;
   localparam logic [3:0] S_ER1  = 4'd11;
   localparam logic [3:0] S_PK   = 4'd12;

   logic [3:0]                  state_ff, state_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [fahq_pkg::RT_W-1:0]   last_rt_ff, last_rt_in;
   logic [fahq_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [fahq_pkg::ID_W-1:0]   id_ff, id_in;
   fahq_pkg::entry_type         mov_ff, mov_in;
   fahq_pkg::entry_type         best_ff, best_in;
   fahq_pkg::entry_type         out_ff, out_in;
   logic [SLOT_W-1:0]           hole_ff, hole_in;
   logic [SLOT_W-1:0]           parent_ff, parent_in;
   logic [SLOT_W-1:0]           best_slot_ff, best_slot_in;
   logic [SLOT_W-1:0]           pend_slot_ff, pend_slot_in;
   logic                        moved_ff, moved_in;
   logic                        pend_ff, pend_in;
   logic [CH_W-1:0]             child_ff, child_in;
   logic [KW-1:0]               k_ff, k_in;
   logic [fahq_pkg::STAT_W-1:0] status_ff, status_in;
   logic                        strobe_ff, strobe_in;
   logic [ID_COUNT-1:0]         valid_ff, valid_in;

   logic                        heap_wr_en, heap_rd_en;
   logic [SLOT_W-1:0]           heap_wr_addr, heap_rd_addr;
   logic [ENT_W-1:0]            heap_wr_data, heap_rd_data;
   logic                        pos_wr_en, pos_rd_en;
   logic [IDX_W-1:0]            pos_wr_addr, pos_rd_addr;
   logic [SLOT_W-1:0]           pos_wr_data, pos_rd_data;

   fahq_pkg::entry_type         rd_entry;
   logic [IDX_W-1:0]            req_idx;
   logic                        id_in_range;
   logic                        id_known;
   logic [PROD_W-1:0]           prod;
   logic [SLOT_W-1:0]           hole_m1;
   logic [CNT_W-1:0]            cnt_m1;
   logic [CH_W-1:0]             first_child;
   logic [3:0]                  up_exit;

   fahq_ram #(.WIDTH(ENT_W), .DEPTH(CAPACITY)) u_slot_ram (
      .clock  (clock),
      .wr_en  (heap_wr_en),
      .wr_addr(heap_wr_addr),
      .wr_data(heap_wr_data),
      .rd_en  (heap_rd_en),
      .rd_addr(heap_rd_addr),
      .rd_data(heap_rd_data)
   );

   fahq_ram #(.WIDTH(SLOT_W), .DEPTH(ID_COUNT)) u_pos_ram (
      .clock  (clock),
      .wr_en  (pos_wr_en),
      .wr_addr(pos_wr_addr),
      .wr_data(pos_wr_data),
      .rd_en  (pos_rd_en),
      .rd_addr(pos_rd_addr),
      .rd_data(pos_rd_data)
   );

   assign rd_entry    = heap_rd_data;
   assign req_idx     = IDX_W'(req_entry_id);
   assign id_in_range = (32'(req_entry_id) < ID_COUNT);
   assign id_known    = id_in_range && valid_ff[req_idx];
   assign hole_m1     = hole_ff - SLOT_W'(1);
   // parent by reciprocal multiply
   assign prod        = PROD_W'(hole_m1) * DIV_M;
   assign cnt_m1      = count_ff - CNT_W'(1);
   assign first_child = CH_W'(hole_ff) * CH_W'(ARITY) + CH_W'(1);
   assign up_exit     = (mode_ff == fahq_pkg::MODE_ERASE && !moved_ff) ? S_DN : S_WR;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      last_rt_in   = last_rt_ff;
      mode_in      = mode_ff;
      id_in        = id_ff;
      mov_in       = mov_ff;
      best_in      = best_ff;
      out_in       = out_ff;
      hole_in      = hole_ff;
      parent_in    = parent_ff;
      best_slot_in = best_slot_ff;
      pend_slot_in = pend_slot_ff;
      moved_in     = moved_ff;
      pend_in      = pend_ff;
      child_in     = child_ff;
      k_in         = k_ff;
      status_in    = status_ff;
      strobe_in    = 1'b0;
      valid_in     = valid_ff;
      heap_wr_en   = 1'b0;
      heap_wr_addr = '0;
      heap_wr_data = '0;
      heap_rd_en   = 1'b0;
      heap_rd_addr = '0;
      pos_wr_en    = 1'b0;
      pos_wr_addr  = '0;
      pos_wr_data  = '0;
      pos_rd_en    = 1'b0;
      pos_rd_addr  = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in   = req_mode;
               id_in     = req_entry_id;
               out_in    = '0;
               status_in = fahq_pkg::ST_OK;
               moved_in  = 1'b0;
               unique case (req_mode)
                  fahq_pkg::MODE_PUSH: begin
                     priority if (!id_in_range) begin
                        status_in = fahq_pkg::ST_ABSENT;
                        strobe_in = 1'b1;
                     end else if (id_known) begin
                        status_in = fahq_pkg::ST_PRESENT;
                        strobe_in = 1'b1;
                     end else if (32'(count_ff) >= CAPACITY) begin
                        status_in = fahq_pkg::ST_FULL;
                        strobe_in = 1'b1;
                     end else begin
                        mov_in.runtime    = req_key_runtime;
                        mov_in.weight     = req_entry_weight;
                        mov_in.id         = req_entry_id;
                        hole_in           = count_ff[SLOT_W-1:0];
                        count_in          = count_ff + CNT_W'(1);
                        valid_in[req_idx] = 1'b1;
                        state_in          = S_UP;
                     end
                  end
                  fahq_pkg::MODE_REMOVE: begin
                     if (count_ff == '0) begin
                        status_in = fahq_pkg::ST_EMPTY;
                        strobe_in = 1'b1;
                     end else begin
                        heap_rd_en = 1'b1;
                        state_in   = S_RM0;
                     end
                  end
                  fahq_pkg::MODE_ERASE: begin
                     if (!id_known) begin
                        status_in = fahq_pkg::ST_ABSENT;
                        strobe_in = 1'b1;
                     end else begin
                        pos_rd_en   = 1'b1;
                        pos_rd_addr = req_idx;
                        state_in    = S_ER0;
                     end
                  end
                  fahq_pkg::MODE_PEEK: begin
                     if (count_ff == '0) begin
                        status_in = fahq_pkg::ST_EMPTY;
                        strobe_in = 1'b1;
                     end else begin
                        heap_rd_en = 1'b1;
                        state_in   = S_PK;
                     end
                  end
               endcase
            end
         end
         S_UP: begin
            if (hole_ff == '0) begin
               state_in = up_exit;
            end else begin
               parent_in = prod[DIV_S +: SLOT_W];
               state_in  = S_UPR;
            end
         end
         S_UPR: begin
            heap_rd_en   = 1'b1;
            heap_rd_addr = parent_ff;
            state_in     = S_UPC;
         end
         S_UPC: begin
            if (fahq_pkg::ranks_ahead(mov_ff, rd_entry)) begin
               heap_wr_en   = 1'b1;
               heap_wr_addr = hole_ff;
               heap_wr_data = heap_rd_data;
               pos_wr_en    = 1'b1;
               pos_wr_addr  = IDX_W'(rd_entry.id);
               pos_wr_data  = hole_ff;
               hole_in      = parent_ff;
               moved_in     = 1'b1;
               state_in     = S_UP;
            end else begin
               state_in = up_exit;
            end
         end
         S_WR: begin
            heap_wr_en   = 1'b1;
            heap_wr_addr = hole_ff;
            heap_wr_data = mov_ff;
            pos_wr_en    = 1'b1;
            pos_wr_addr  = IDX_W'(mov_ff.id);
            pos_wr_data  = hole_ff;
            strobe_in    = 1'b1;
            state_in     = S_IDLE;
         end
         S_DN: begin
            child_in     = first_child;
            k_in         = '0;
            best_in      = mov_ff;
            best_slot_in = hole_ff;
            pend_in      = 1'b0;
            state_in     = S_DNS;
         end
         S_DNS: begin
            if (pend_ff && fahq_pkg::ranks_ahead(rd_entry, best_ff)) begin
               best_in      = rd_entry;
               best_slot_in = pend_slot_ff;
            end
            if (k_ff < KW'(ARITY) && child_ff < CH_W'(count_ff)) begin
               heap_rd_en   = 1'b1;
               heap_rd_addr = child_ff[SLOT_W-1:0];
               pend_in      = 1'b1;
               pend_slot_in = child_ff[SLOT_W-1:0];
               child_in     = child_ff + CH_W'(1);
               k_in         = k_ff + KW'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = S_DNE;
               end
            end
         end
         S_DNE: begin
            if (best_slot_ff == hole_ff) begin
               state_in = S_WR;
            end else begin
               heap_wr_en   = 1'b1;
               heap_wr_addr = hole_ff;
               heap_wr_data = best_ff;
               pos_wr_en    = 1'b1;
               pos_wr_addr  = IDX_W'(best_ff.id);
               pos_wr_data  = hole_ff;
               hole_in      = best_slot_ff;
               state_in     = S_DN;
            end
         end
         S_RM0: begin
            out_in       = rd_entry;
            heap_rd_en   = 1'b1;
            heap_rd_addr = cnt_m1[SLOT_W-1:0];
            count_in     = cnt_m1;
            state_in     = S_RM1;
         end
         S_RM1: begin
            mov_in                     = rd_entry;
            last_rt_in                 = out_ff.runtime;
            valid_in[IDX_W'(out_ff.id)] = 1'b0;
            if (count_ff == '0) begin
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end else begin
               hole_in  = '0;
               state_in = S_DN;
            end
         end
         S_ER0: begin
            hole_in      = pos_rd_data;
            heap_rd_en   = 1'b1;
            heap_rd_addr = cnt_m1[SLOT_W-1:0];
            count_in     = cnt_m1;
            state_in     = S_ER1;
         end
         S_ER1: begin
            mov_in                    = rd_entry;
            valid_in[IDX_W'(id_ff)]   = 1'b0;
            if (CNT_W'(hole_ff) == count_ff) begin
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end else begin
               state_in = S_UP;
            end
         end
         S_PK: begin
            out_in    = rd_entry;
            strobe_in = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         last_rt_ff <= '0;
         strobe_ff  <= 1'b0;
         valid_ff   <= '0;
         status_ff  <= fahq_pkg::ST_OK;
         out_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         last_rt_ff <= last_rt_in;
         strobe_ff  <= strobe_in;
         valid_ff   <= valid_in;
         status_ff  <= status_in;
         out_ff     <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      id_ff        <= id_in;
      mov_ff       <= mov_in;
      best_ff      <= best_in;
      hole_ff      <= hole_in;
      parent_ff    <= parent_in;
      best_slot_ff <= best_slot_in;
      pend_slot_ff <= pend_slot_in;
      moved_ff     <= moved_in;
      pend_ff      <= pend_in;
      child_ff     <= child_in;
      k_ff         <= k_in;
   end

   assign busy                     = (state_ff != S_IDLE);
   assign rsp_strobe               = strobe_ff;
   assign rsp_status               = status_ff;
   assign rsp_out_id               = out_ff.id;
   assign rsp_out_runtime          = out_ff.runtime;
   assign rsp_out_weight           = out_ff.weight;
   assign rsp_entry_count          = count_ff;
   assign rsp_last_removed_runtime = last_rt_ff;

endmodule

`default_nettype wire

@@ hw/rtl/fahq_checker.sv @@
// ----------------------------------------------------------------------------
// heap queue checker
// port-level checks on the heap queue core, bound into the core module
// ----------------------------------------------------------------------------
`default_nettype none
`include "four_ary_min_heap_queue_core_macros.svh"

module fahq_checker #(
   parameter int CAPACITY = fahq_pkg::DEF_CAPACITY,
   localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        start,
   input wire logic                        busy,
   input wire logic                        rsp_strobe,
   input wire logic [fahq_pkg::STAT_W-1:0] rsp_status,
   input wire logic [fahq_pkg::ID_W-1:0]   rsp_out_id,
   input wire logic [fahq_pkg::RT_W-1:0]   rsp_out_runtime,
   input wire logic [fahq_pkg::WT_W-1:0]   rsp_out_weight,
   input wire logic [CNT_W-1:0]            rsp_entry_count
);

   `FAHQ_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, busy || rsp_strobe, "accepted word neither busy nor answered")

   `FAHQ_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_strobe, !busy, "result word while busy")

   `FAHQ_ASSERT_NOW(a_error_zero, clock, reset, rsp_strobe && rsp_status != fahq_pkg::ST_OK, rsp_out_id == '0 && rsp_out_runtime == '0 && rsp_out_weight == '0, "error word carries entry data")

   `FAHQ_ASSERT_NOW(a_count_cap, clock, reset, rsp_strobe, 32'(rsp_entry_count) <= CAPACITY, "entry count above capacity")

endmodule

bind four_ary_min_heap_queue_core fahq_checker #(.CAPACITY(CAPACITY)) u_fahq_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_status     (rsp_status),
   .rsp_out_id     (rsp_out_id),
   .rsp_out_runtime(rsp_out_runtime),
   .rsp_out_weight (rsp_out_weight),
   .rsp_entry_count(rsp_entry_count)
);

`default_nettype wire

@@ tb/four_ary_min_heap_queue_core_checker.sv @@
// ----------------------------------------------------------------------------
// heap queue checker
// Watches the command and result channels of the heap queue core, keeps its
// own copy of the heap, the id slot map and the last removed runtime, works
// out the result word of every accepted command and compares each result
// word field by field with the oldest one still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module four_ary_min_heap_queue_core_checker (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic                        busy,
   input  wire logic [fahq_pkg::MODE_W-1:0] req_mode,
   input  wire logic [fahq_pkg::ID_W-1:0]   req_entry_id,
   input  wire logic [fahq_pkg::RT_W-1:0]   req_key_runtime,
   input  wire logic [fahq_pkg::WT_W-1:0]   req_entry_weight,
   input  wire logic                        rsp_strobe,
   input  wire logic [fahq_pkg::STAT_W-1:0] rsp_status,
   input  wire logic [fahq_pkg::ID_W-1:0]   rsp_out_id,
   input  wire logic [fahq_pkg::RT_W-1:0]   rsp_out_runtime,
   input  wire logic [fahq_pkg::WT_W-1:0]   rsp_out_weight,
   input  wire logic [8:0]                  rsp_entry_count,
   input  wire logic [fahq_pkg::RT_W-1:0]   rsp_last_removed_runtime,
   output int                               fail_count,
   output int                               pending_count
);

   localparam int SLOTS = fahq_pkg::DEF_CAPACITY;
   localparam int WAYS  = fahq_pkg::DEF_ARITY;
   localparam int IDS   = fahq_pkg::DEF_ID_COUNT;

   typedef struct packed {
      logic [fahq_pkg::STAT_W-1:0] status;
      logic [fahq_pkg::ID_W-1:0]   id;
      logic [fahq_pkg::RT_W-1:0]   runtime;
      logic [fahq_pkg::WT_W-1:0]   weight;
      logic [8:0]                  count;
      logic [fahq_pkg::RT_W-1:0]   last_rt;
   } queue_word_type;

   fahq_pkg::entry_type       heap_slot [SLOTS];
   int                        slot_of [IDS];
   bit                        id_live [IDS];
   int                        held;
   logic [fahq_pkg::RT_W-1:0] last_taken_rt;
   queue_word_type            awaited_words [$];

   function automatic bit outranks(fahq_pkg::entry_type a, fahq_pkg::entry_type b);
      if (a.runtime != b.runtime) return a.runtime < b.runtime;
      return a.weight > b.weight;
   endfunction

   function void exchange(int i, int j);
      fahq_pkg::entry_type t;
      t = heap_slot[i];
      heap_slot[i] = heap_slot[j];
      heap_slot[j] = t;
      slot_of[heap_slot[i].id] = i;
      slot_of[heap_slot[j].id] = j;
   endfunction

   function void climb(int s);
      int up;
      while (s > 0) begin
         up = (s - 1) / WAYS;
         if (!outranks(heap_slot[s], heap_slot[up])) break;
         exchange(s, up);
         s = up;
      end
   endfunction

   function void descend(int s);
      int best;
      int c;
      while (1) begin
         best = s;
         for (int k = 0; k < WAYS; k++) begin
            c = s * WAYS + 1 + k;
            if (c < held && outranks(heap_slot[c], heap_slot[best])) best = c;
         end
         if (best == s) break;
         exchange(s, best);
         s = best;
      end
   endfunction

   function queue_word_type queue_outcome(logic [fahq_pkg::MODE_W-1:0] mode,
                                          logic [fahq_pkg::ID_W-1:0] id,
                                          logic [fahq_pkg::RT_W-1:0] rt,
                                          logic [fahq_pkg::WT_W-1:0] wt);
      queue_word_type w;
      int s;
      int last;
      w = '0;
      w.status = fahq_pkg::ST_OK;
      case (mode)
         fahq_pkg::MODE_PUSH: begin
            if (id_live[id]) begin
               w.status = fahq_pkg::ST_PRESENT;
            end else if (held >= SLOTS) begin
               w.status = fahq_pkg::ST_FULL;
            end else begin
               heap_slot[held] = '{runtime: rt, weight: wt, id: id};
               id_live[id] = 1'b1;
               slot_of[id] = held;
               held++;
               climb(held - 1);
            end
         end
         fahq_pkg::MODE_REMOVE: begin
            if (held == 0) begin
               w.status = fahq_pkg::ST_EMPTY;
            end else begin
               last = held - 1;
               held--;
               if (last != 0) begin
                  exchange(0, last);
                  descend(0);
               end
               w.id = heap_slot[last].id;
               w.runtime = heap_slot[last].runtime;
               w.weight = heap_slot[last].weight;
               last_taken_rt = heap_slot[last].runtime;
               id_live[heap_slot[last].id] = 1'b0;
            end
         end
         fahq_pkg::MODE_ERASE: begin
            if (!id_live[id] || slot_of[id] >= held) begin
               w.status = fahq_pkg::ST_ABSENT;
            end else begin
               s = slot_of[id];
               last = held - 1;
               held--;
               if (last != s) begin
                  exchange(s, last);
                  climb(s);
                  descend(s);
               end
               id_live[id] = 1'b0;
            end
         end
         default: begin
            if (held == 0) begin
               w.status = fahq_pkg::ST_EMPTY;
            end else begin
               w.id = heap_slot[0].id;
               w.runtime = heap_slot[0].runtime;
               w.weight = heap_slot[0].weight;
            end
         end
      endcase
      w.count = held[8:0];
      w.last_rt = last_taken_rt;
      return w;
   endfunction

   task check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $realtime, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      queue_word_type w;
      if (reset) begin
         held = 0;
         last_taken_rt = '0;
         for (int i = 0; i < IDS; i++) id_live[i] = 1'b0;
         awaited_words.delete();
         fail_count = 0;
         pending_count <= 0;
      end else begin
         if (rsp_strobe) begin
            if (awaited_words.size() == 0) begin
               $display("%0t: result word with none expected, status %h", $realtime,
                        rsp_status);
               fail_count++;
            end else begin
               w = awaited_words.pop_front();
               check_field("status", 64'(w.status), 64'(rsp_status));
               check_field("out_id", 64'(w.id), 64'(rsp_out_id));
               check_field("out_runtime", w.runtime, rsp_out_runtime);
               check_field("out_weight", 64'(w.weight), 64'(rsp_out_weight));
               check_field("entry_count", 64'(w.count), 64'(rsp_entry_count));
               check_field("last_removed_runtime", w.last_rt, rsp_last_removed_runtime);
            end
         end
         if (start && !busy)
            awaited_words.push_back(queue_outcome(req_mode, req_entry_id,
                                                  req_key_runtime, req_entry_weight));
         pending_count <= awaited_words.size();
      end
   end

endmodule

`default_nettype wire

@@ tb/tb_four_ary_min_heap_queue_core.sv @@
// ----------------------------------------------------------------------------
// heap queue core testbench
// Drives directed and random push, remove, erase and peek words into the
// core with random gaps, fills the heap to capacity and then takes part of it
// out again, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_four_ary_min_heap_queue_core;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic [fahq_pkg::MODE_W-1:0] req_mode = fahq_pkg::MODE_PEEK;
   logic [fahq_pkg::ID_W-1:0]   req_entry_id = '0;
   logic [fahq_pkg::RT_W-1:0]   req_key_runtime = '0;
   logic [fahq_pkg::WT_W-1:0]   req_entry_weight = '0;
   logic                        rsp_strobe;
   logic [fahq_pkg::STAT_W-1:0] rsp_status;
   logic [fahq_pkg::ID_W-1:0]   rsp_out_id;
   logic [fahq_pkg::RT_W-1:0]   rsp_out_runtime;
   logic [fahq_pkg::WT_W-1:0]   rsp_out_weight;
   logic [8:0]                  rsp_entry_count;
   logic [fahq_pkg::RT_W-1:0]   rsp_last_removed_runtime;
   int                          fail_count;
   int                          pending_count;
   int                          quiet_cycles = 0;
   bit                          calm = 1'b0;

   always #4 clock = ~clock;

   four_ary_min_heap_queue_core u_dut (
      .clock, .reset, .start, .busy,
      .req_mode, .req_entry_id, .req_key_runtime, .req_entry_weight,
      .rsp_strobe, .rsp_status, .rsp_out_id, .rsp_out_runtime, .rsp_out_weight,
      .rsp_entry_count, .rsp_last_removed_runtime
   );

   four_ary_min_heap_queue_core_checker u_checker (
      .clock, .reset, .start, .busy,
      .req_mode, .req_entry_id, .req_key_runtime, .req_entry_weight,
      .rsp_strobe, .rsp_status, .rsp_out_id, .rsp_out_runtime, .rsp_out_weight,
      .rsp_entry_count, .rsp_last_removed_runtime,
      .fail_count, .pending_count
   );

   // watchdog on cycles with no word moving
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > 3000) begin
            $display("four_ary_min_heap_queue_core verification failed");
            $finish;
         end
      end
   end

   task send_word(logic [fahq_pkg::MODE_W-1:0] mode, logic [fahq_pkg::ID_W-1:0] id,
                  logic [fahq_pkg::RT_W-1:0] rt, logic [fahq_pkg::WT_W-1:0] wt);
      if (!calm && $urandom_range(99) < 25) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      start <= 1'b1;
      req_mode <= mode;
      req_entry_id <= id;
      req_key_runtime <= rt;
      req_entry_weight <= wt;
      do @(posedge clock); while (busy);
   endtask

   function automatic logic [63:0] pick_runtime();
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: return 64'($urandom_range(15));
         6, 7:             return {$urandom, $urandom};
         8:                return '1;
         default:          return '0;
      endcase
   endfunction

   function automatic logic [15:0] pick_weight();
      case ($urandom_range(5))
         0, 1, 2: return 16'($urandom_range(3));
         3:       return '1;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_id();
      if ($urandom_range(9) < 8) return 8'($urandom_range(31));
      return 8'($urandom_range(255));
   endfunction

   task mixed_word();
      int r;
      r = $urandom_range(99);
      if (r < 45)
         send_word(fahq_pkg::MODE_PUSH, pick_id(), pick_runtime(), pick_weight());
      else if (r < 70)
         send_word(fahq_pkg::MODE_REMOVE, 8'($urandom), {$urandom, $urandom},
                   16'($urandom));
      else if (r < 88)
         send_word(fahq_pkg::MODE_ERASE, pick_id(), {$urandom, $urandom}, 16'($urandom));
      else
         send_word(fahq_pkg::MODE_PEEK, 8'($urandom), {$urandom, $urandom},
                   16'($urandom));
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words
      send_word(fahq_pkg::MODE_PEEK, 8'd0, '0, '0);
      send_word(fahq_pkg::MODE_REMOVE, 8'd0, '0, '0);
      send_word(fahq_pkg::MODE_ERASE, 8'd0, '0, '0);
      send_word(fahq_pkg::MODE_PUSH, 8'd0, '0, '0);
      send_word(fahq_pkg::MODE_PUSH, 8'd255, '1, '1);
      send_word(fahq_pkg::MODE_PUSH, 8'd0, 64'd5, 16'd5);
      send_word(fahq_pkg::MODE_PUSH, 8'd7, '1, 16'd0);
      send_word(fahq_pkg::MODE_PUSH, 8'd8, 64'd9, 16'd1);
      send_word(fahq_pkg::MODE_PUSH, 8'd9, 64'd9, 16'd100);
      send_word(fahq_pkg::MODE_PUSH, 8'd10, 64'd9, 16'd100);
      send_word(fahq_pkg::MODE_PEEK, 8'd0, '0, '0);
      send_word(fahq_pkg::MODE_ERASE, 8'd255, '0, '0);
      send_word(fahq_pkg::MODE_ERASE, 8'd255, '0, '0);
      send_word(fahq_pkg::MODE_ERASE, 8'd9, '0, '0);
      repeat (7) send_word(fahq_pkg::MODE_REMOVE, 8'd0, '0, '0);
      send_word(fahq_pkg::MODE_PEEK, 8'd0, '0, '0);

      for (int i = 0; i < 160; i++) begin
         calm = (i >= 60 && i < 130);
         mixed_word();
      end
      calm = 1'b0;
      // fill every id, then duplicates at capacity
      for (int i = 0; i < 256; i++)
         send_word(fahq_pkg::MODE_PUSH, i[7:0], pick_runtime(), pick_weight());
      repeat (4)
         send_word(fahq_pkg::MODE_PUSH, 8'($urandom), {$urandom, $urandom},
                   16'($urandom));
      send_word(fahq_pkg::MODE_PEEK, 8'd0, '0, '0);
      for (int i = 0; i < 60; i++) begin
         if ($urandom_range(3) == 0) send_word(fahq_pkg::MODE_ERASE, 8'($urandom), '0, '0);
         else                        send_word(fahq_pkg::MODE_REMOVE, 8'd0, '0, '0);
      end
      for (int i = 0; i < 50; i++) mixed_word();
      start <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0) begin
         $display("four_ary_min_heap_queue_core verification clean");
      end else begin
         $display("four_ary_min_heap_queue_core verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/fahq_pkg.sv
hw/rtl/fahq_ram.sv
hw/rtl/four_ary_min_heap_queue_core.sv
hw/rtl/fahq_checker.sv
tb/four_ary_min_heap_queue_core_checker.sv
tb/tb_four_ary_min_heap_queue_core.sv
